### design/rpn_stack_evaluator_top_assert.svh
// Assertion macros for the reverse Polish evaluator checker.
// Included by the checker file; depends on nothing else.
`ifndef RPN_STACK_EVALUATOR_TOP_ASSERT_SVH
`define RPN_STACK_EVALUATOR_TOP_ASSERT_SVH

// Clocked assertion, switched off while reset is high
`define RSE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked assertion that is also checked during reset
`define RSE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

### design/rse_pkg.sv
// Shared types, codes and saturation helpers for the reverse Polish evaluator.
// No dependencies; every file but rse_ram and the assertion header uses it.
package rse_pkg;

   localparam int DATA_W   = 32;
   localparam int FUNC_W   = 3;
   localparam int STATUS_W = 2;

   // token kinds
   typedef enum logic [FUNC_W-1:0] {
      FN_PUSH = 3'd0,
      FN_ADD  = 3'd1,
      FN_SUB  = 3'd2,
      FN_MUL  = 3'd3,
      FN_DIV  = 3'd4
   } func_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_UNDERFLOW = 2'd1,
      ST_OVERFLOW  = 2'd2,
      ST_DIVZERO   = 2'd3
   } status_type;

   // controller states
   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_OPER,
      S_MULWB,
      S_DIV,
      S_DIVWB,
      S_END
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic       capture;
      logic       push;
      logic       err_valid;
      status_type err_code;
      logic       read_left;
      logic       operate;
      logic       mul_wb;
      logic       div_step;
      logic       div_wb;
      logic       emit;
   } dp_cmd_type;

   // datapath to controller status
   typedef struct packed {
      func_type func;
      logic     last;
      logic     stack_full;
      logic     two_ok;
      logic     right_zero;
      logic     div_done;
   } dp_sts_type;

   // magnitude of a signed word; the most negative value maps to 2^31
   function automatic logic [DATA_W-1:0] mag_of(input logic [DATA_W-1:0] x);
      logic [DATA_W-1:0] m;
      m = x[DATA_W-1] ? (~x + 1'b1) : x;
      return m;
   endfunction

   // apply sign to a magnitude and clamp to the signed word range
   function automatic logic [DATA_W-1:0] sat_signed(input logic neg, input logic big,
                                                    input logic [DATA_W-2:0] low);
      logic [DATA_W-1:0] r;
      if (big) begin
         r = neg ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
         r = neg ? (~{1'b0, low} + 1'b1) : {1'b0, low};
      end
      return r;
   endfunction

   // clamp a sum that carries one guard bit
   function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W:0] s);
      logic [DATA_W-1:0] r;
      if (s[DATA_W] != s[DATA_W-1]) begin
         r = s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
         r = s[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

### design/rse_req_if.sv
// Token channel of the reverse Polish evaluator: valid, ready and token payload.
// Depends on rse_pkg for field widths.
interface rse_req_if;
   import rse_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [FUNC_W-1:0]        func;
   logic signed [DATA_W-1:0] operand_value;
   logic                     end_of_expression;

   modport source (output valid, output func, output operand_value,
                   output end_of_expression, input ready);
   modport sink   (input valid, input func, input operand_value,
                   input end_of_expression, output ready);
   modport mon    (input valid, input ready, input func, input operand_value,
                   input end_of_expression);
endinterface

### design/rse_rsp_if.sv
// Result channel of the reverse Polish evaluator: valid, ready and result payload.
// Depends on rse_pkg for field widths.
interface rse_rsp_if;
   import rse_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] final_value;
   logic [STATUS_W-1:0]      status;

   modport source (output valid, output final_value, output status, input ready);
   modport sink   (input valid, input final_value, input status, output ready);
   modport mon    (input valid, input ready, input final_value, input status);
endinterface

### design/rpn_stack_evaluator_top.sv
// Reverse Polish expression evaluator on a Q16.16 operand stack.
// Channels: req_ch takes one token per transfer (func, operand_value,
// end_of_expression); rsp_ch gives one result (final_value, status) for
// each token marked end_of_expression. Both use valid/ready; a transfer
// happens on a rising edge with both high.
// Tokens are handled one at a time through IDLE, DECODE and END; add and
// subtract also pass OPER, multiply OPER and MULWB (one 32x32 multiply
// then a saturation stage), divide OPER, DIV (the one-bit-per-cycle
// restoring divider) and DIVWB unless the divisor is zero. An operator with
// too few operands skips to END. The last token's END loads the result.
// Results saturate to the signed 32-bit range; the first error of an
// expression is reported in status and the stack empties after the result.
// Reset (synchronous, active high) empties the stack, clears the error and
// drops any pending result. The stack contents need no clearing.
// A stalled receiver holds the result; further tokens are still taken
// until another final token needs the result register, which then waits.
// Depends on rse_pkg, rse_req_if, rse_rsp_if, rse_ram, rse_dp, rse_ctrl.
module rpn_stack_evaluator_top #(
   parameter int STACK_DEPTH = 16,
   parameter int FRAC_BITS   = 16
) (
   input logic      clock,
   input logic      reset,
   rse_req_if.sink  req_ch,
   rse_rsp_if.source rsp_ch
);
   import rse_pkg::*;

   localparam int AW = $clog2(STACK_DEPTH);

   dp_cmd_type        cmd;
   dp_sts_type        sts;
   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   logic [DATA_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [AW-1:0]     ram_rd_addr;
   logic [DATA_W-1:0] ram_rd_data;

   // sequencing
   rse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // arithmetic, stack top and result register
   rse_dp #(
      .STACK_DEPTH (STACK_DEPTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .sts                   (sts),
      .req_func              (req_ch.func),
      .req_operand_value     (req_ch.operand_value),
      .req_end_of_expression (req_ch.end_of_expression),
      .rsp_final_value       (rsp_ch.final_value),
      .rsp_status            (rsp_ch.status),
      .ram_wr_en             (ram_wr_en),
      .ram_wr_addr           (ram_wr_addr),
      .ram_wr_data           (ram_wr_data),
      .ram_rd_en             (ram_rd_en),
      .ram_rd_addr           (ram_rd_addr),
      .ram_rd_data           (ram_rd_data)
   );

   // stack entries below the top
   rse_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );
endmodule

### design/rse_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module rse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write, then register the read word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

### design/rse_dp.sv
// Datapath of the reverse Polish evaluator: token register, stack top, count,
// error latch, add/sub, multiplier, restoring divider and result register.
// Depends on rse_pkg; the stack below the top lives in an external rse_ram.
module rse_dp #(
   parameter int STACK_DEPTH = 16,
   parameter int FRAC_BITS   = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  rse_pkg::dp_cmd_type                 cmd,
   output rse_pkg::dp_sts_type                 sts,
   input  logic [rse_pkg::FUNC_W-1:0]          req_func,
   input  logic signed [rse_pkg::DATA_W-1:0]   req_operand_value,
   input  logic                                req_end_of_expression,
   output logic signed [rse_pkg::DATA_W-1:0]   rsp_final_value,
   output logic [rse_pkg::STATUS_W-1:0]        rsp_status,
   output logic                                ram_wr_en,
   output logic [$clog2(STACK_DEPTH)-1:0]      ram_wr_addr,
   output logic [rse_pkg::DATA_W-1:0]          ram_wr_data,
   output logic                                ram_rd_en,
   output logic [$clog2(STACK_DEPTH)-1:0]      ram_rd_addr,
   input  logic [rse_pkg::DATA_W-1:0]          ram_rd_data
);
   import rse_pkg::*;

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int DW = DATA_W + FRAC_BITS;
   localparam int KW = $clog2(DW + 1);
   localparam int PW = 2 * DATA_W;

   func_type          func_ff,  func_in;
   logic [DATA_W-1:0] value_ff, value_in;
   logic              last_ff,  last_in;
   logic [DATA_W-1:0] top_ff,   top_in;
   logic [CW-1:0]     count_ff, count_in;
   status_type        err_ff,   err_in;
   logic              neg_ff,   neg_in;
   logic [PW-1:0]     prod_ff,  prod_in;
   logic [DATA_W-1:0] rem_ff,   rem_in;
   logic [DW-1:0]     quo_ff,   quo_in;
   logic [DATA_W-1:0] dvs_ff,   dvs_in;
   logic [KW-1:0]     step_ff,  step_in;
   logic [DATA_W-1:0] fval_ff,  fval_in;
   status_type        fstat_ff, fstat_in;

   logic [DATA_W-1:0] left;
   logic [DATA_W-1:0] mag_l;
   logic [DATA_W-1:0] mag_r;
   logic [DATA_W:0]   sum_ext;
   logic [DATA_W:0]   dif_ext;
   logic [PW-1:0]     prod_full;
   logic [PW-1:0]     prod_shift;
   logic [DATA_W-1:0] mul_res;
   logic [DATA_W:0]   trial;
   logic [DATA_W:0]   trial_sub;
   logic              trial_ge;
   logic [DATA_W-1:0] div_res;
   logic [CW-1:0]     cnt_m1;
   logic [CW-1:0]     cnt_m2;

   // operands: left from the RAM, right is the held stack top
   assign left      = ram_rd_data;
   assign mag_l     = mag_of(left);
   assign mag_r     = mag_of(top_ff);
   assign sum_ext   = {left[DATA_W-1], left} + {top_ff[DATA_W-1], top_ff};
   assign dif_ext   = {left[DATA_W-1], left} - {top_ff[DATA_W-1], top_ff};
   assign prod_full = {{DATA_W{1'b0}}, mag_l} * {{DATA_W{1'b0}}, mag_r};

   // scale and clamp the registered product
   assign prod_shift = prod_ff >> FRAC_BITS;
   assign mul_res    = sat_signed(neg_ff, |prod_shift[PW-1:DATA_W-1],
                                  prod_shift[DATA_W-2:0]);

   // one restoring divide step: shift in the next dividend bit, try subtract
   assign trial     = {rem_ff, quo_ff[DW-1]};
   assign trial_sub = trial - {1'b0, dvs_ff};
   assign trial_ge  = (trial >= {1'b0, dvs_ff});
   assign div_res   = sat_signed(neg_ff, |quo_ff[DW-1:DATA_W-1], quo_ff[DATA_W-2:0]);

   assign cnt_m1 = count_ff - CW'(1);
   assign cnt_m2 = count_ff - CW'(2);

   // stack below the top: old top moves down on push, left operand read on op
   assign ram_wr_en   = cmd.push && (count_ff != '0);
   assign ram_wr_addr = cnt_m1[AW-1:0];
   assign ram_wr_data = top_ff;
   assign ram_rd_en   = cmd.read_left;
   assign ram_rd_addr = cnt_m2[AW-1:0];

   // next register values
   always_comb begin
      func_in  = func_ff;
      value_in = value_ff;
      last_in  = last_ff;
      top_in   = top_ff;
      count_in = count_ff;
      err_in   = err_ff;
      neg_in   = neg_ff;
      prod_in  = prod_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      step_in  = step_ff;
      fval_in  = fval_ff;
      fstat_in = fstat_ff;

      if (cmd.capture) begin
         func_in  = func_type'(req_func);
         value_in = req_operand_value;
         last_in  = req_end_of_expression;
      end

      if (cmd.push) begin
         top_in   = value_ff;
         count_in = count_ff + CW'(1);
      end

      if (cmd.operate) begin
         neg_in = left[DATA_W-1] ^ top_ff[DATA_W-1];
         case (func_ff)
            FN_ADD: begin
               top_in   = sat_add(sum_ext);
               count_in = cnt_m1;
            end
            FN_SUB: begin
               top_in   = sat_add(dif_ext);
               count_in = cnt_m1;
            end
            FN_MUL: begin
               prod_in = prod_full;
            end
            FN_DIV: begin
               if (top_ff == '0) begin
                  top_in   = '0;
                  count_in = cnt_m1;
               end else begin
                  rem_in  = '0;
                  quo_in  = DW'(mag_l) << FRAC_BITS;
                  dvs_in  = mag_r;
                  step_in = KW'(DW);
               end
            end
            default: begin
            end
         endcase
      end

      if (cmd.div_step) begin
         rem_in  = trial_ge ? trial_sub[DATA_W-1:0] : trial[DATA_W-1:0];
         quo_in  = {quo_ff[DW-2:0], trial_ge};
         step_in = step_ff - KW'(1);
      end

      if (cmd.mul_wb) begin
         top_in   = mul_res;
         count_in = cnt_m1;
      end

      if (cmd.div_wb) begin
         top_in   = div_res;
         count_in = cnt_m1;
      end

      // keep only the first error of the expression
      if (cmd.err_valid && (err_ff == ST_OK)) begin
         err_in = cmd.err_code;
      end

      // load the result and empty the stack for the next expression
      if (cmd.emit) begin
         fval_in  = (count_ff != '0) ? top_ff : '0;
         fstat_in = ((count_ff == '0) && (err_ff == ST_OK)) ? ST_UNDERFLOW : err_ff;
         count_in = '0;
         err_in   = ST_OK;
      end
   end

   // registers; count, error and step counter are control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         err_ff   <= ST_OK;
         step_ff  <= '0;
      end else begin
         count_ff <= count_in;
         err_ff   <= err_in;
         step_ff  <= step_in;
      end
      func_ff  <= func_in;
      value_ff <= value_in;
      last_ff  <= last_in;
      top_ff   <= top_in;
      neg_ff   <= neg_in;
      prod_ff  <= prod_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      dvs_ff   <= dvs_in;
      fval_ff  <= fval_in;
      fstat_ff <= fstat_in;
   end

   // status back to the controller
   assign sts.func       = func_ff;
   assign sts.last       = last_ff;
   assign sts.stack_full = (count_ff == CW'(STACK_DEPTH));
   assign sts.two_ok     = (count_ff >= CW'(2));
   assign sts.right_zero = (top_ff == '0);
   assign sts.div_done   = (step_ff == KW'(1));

   assign rsp_final_value = fval_ff;
   assign rsp_status      = fstat_ff;
endmodule

### design/rse_ctrl.sv
// Controller of the reverse Polish evaluator: token sequencing state machine
// and result valid flag. Depends on rse_pkg; drives rse_dp by command struct.
module rse_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  rse_pkg::dp_sts_type sts,
   output rse_pkg::dp_cmd_type cmd
);
   import rse_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // the result register can take a value if empty or drained this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (sts.func)
               FN_ADD, FN_SUB, FN_MUL, FN_DIV: begin
                  state_in = sts.two_ok ? S_OPER : S_END;
               end
               default: begin
                  state_in = S_END;
               end
            endcase
         end
         S_OPER: begin
            if (sts.func == FN_MUL) begin
               state_in = S_MULWB;
            end else if ((sts.func == FN_DIV) && !sts.right_zero) begin
               state_in = S_DIV;
            end else begin
               state_in = S_END;
            end
         end
         S_MULWB: begin
            state_in = S_END;
         end
         S_DIV: begin
            if (sts.div_done) begin
               state_in = S_DIVWB;
            end
         end
         S_DIVWB: begin
            state_in = S_END;
         end
         S_END: begin
            if (!sts.last || out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // commands to the datapath
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         S_DECODE: begin
            case (sts.func)
               FN_PUSH: begin
                  if (sts.stack_full) begin
                     cmd.err_valid = 1'b1;
                     cmd.err_code  = ST_OVERFLOW;
                  end else begin
                     cmd.push = 1'b1;
                  end
               end
               FN_ADD, FN_SUB, FN_MUL, FN_DIV: begin
                  if (sts.two_ok) begin
                     cmd.read_left = 1'b1;
                  end else begin
                     cmd.err_valid = 1'b1;
                     cmd.err_code  = ST_UNDERFLOW;
                  end
               end
               default: begin
               end
            endcase
         end
         S_OPER: begin
            cmd.operate = 1'b1;
            if ((sts.func == FN_DIV) && sts.right_zero) begin
               cmd.err_valid = 1'b1;
               cmd.err_code  = ST_DIVZERO;
            end
         end
         S_MULWB: begin
            cmd.mul_wb = 1'b1;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
         end
         S_DIVWB: begin
            cmd.div_wb = 1'b1;
         end
         S_END: begin
            cmd.emit = sts.last && out_free;
         end
         default: begin
         end
      endcase
   end

   // hold the result valid until the transfer completes
   assign rsp_valid_in = cmd.emit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

### design/rse_checker.sv
// Port-level checks for the reverse Polish evaluator, bound to the top level.
// Depends on rse_pkg and rpn_stack_evaluator_top_assert.svh.
`include "rpn_stack_evaluator_top_assert.svh"

module rse_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [rse_pkg::DATA_W-1:0] rsp_final_value,
   input logic [rse_pkg::STATUS_W-1:0]      rsp_status
);
   // a stalled result stays offered
   `RSE_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "result dropped while stalled")

   // a stalled result keeps its payload
   `RSE_ASSERT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_final_value) && $stable(rsp_status), "result changed while stalled")

   // one token at a time: ready drops after each transfer
   `RSE_ASSERT(a_one_token, clock, reset, req_valid && req_ready |=> !req_ready, "token taken while busy")

   // no result pending straight after reset
   `RSE_ASSERT_ALWAYS(a_reset_clear, clock, reset |=> !rsp_valid, "result valid after reset")
endmodule

bind rpn_stack_evaluator_top rse_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_final_value (rsp_ch.final_value),
   .rsp_status      (rsp_ch.status)
);
